// ----- sv/icmp_echo_responder_macros.svh -----
// Assertion helpers for the file that checks the block.
`ifndef ICMP_ECHO_RESPONDER_MACROS_SVH
`define ICMP_ECHO_RESPONDER_MACROS_SVH

// Check on every edge outside reset.
`define ER_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every edge, reset included.
`define ER_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/icmp_er_pkg.sv -----
package icmp_er_pkg;

  localparam int LEN_W = 7;

  localparam logic [15:0] HDR_MIN = 16'd8;
  localparam logic [3:0] PING_LAST = 4'd11;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_REPLY = 2'd1;
  localparam logic [1:0] KIND_IGNORE = 2'd2;

  localparam logic [7:0] TYPE_ECHO_REPLY = 8'd0;
  localparam logic [7:0] TYPE_ECHO_REQ = 8'd8;

  typedef enum logic [1:0] {
    OP_REPLY,
    OP_IGNORE,
    OP_ECHO,
    OP_PING
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [LEN_W-1:0] len;
    logic             bank;
    logic [15:0]      cs;
    logic [31:0]      addr;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // Echo request to the peer, checksum already folded in.
  function automatic logic [7:0] ping_byte(input logic [3:0] idx);
    logic [7:0] v;
    case (idx)
      4'd0: v = 8'h08;
      4'd1: v = 8'h00;
      4'd2: v = 8'hA2;
      4'd3: v = 8'h88;
      4'd4: v = 8'h01;
      4'd5: v = 8'h01;
      4'd6: v = 8'h10;
      4'd7: v = 8'h10;
      4'd8: v = 8'h11;
      4'd9: v = 8'h22;
      4'd10: v = 8'h33;
      4'd11: v = 8'h44;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/icmp_er_in_if.sv -----
interface icmp_er_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [31:0] ip_addr;

  modport source(output valid, req_type, data_byte, last_byte, ip_addr, input ready);
  modport sink(input valid, req_type, data_byte, last_byte, ip_addr, output ready);
endinterface

// ----- sv/icmp_er_out_if.sv -----
interface icmp_er_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [31:0] peer_addr;
  logic        host_available;

  modport source(output valid, kind, out_byte, out_last, peer_addr, host_available,
                 input ready);
  modport sink(input valid, kind, out_byte, out_last, peer_addr, host_available,
               output ready);
endinterface

// ----- sv/icmp_echo_responder.sv -----
// Beat channels
//   channel  | dir | handshake     | payload
//   in_if    | in  | valid / ready | req_type, data_byte, last_byte, ip_addr
//   out_if   | out | valid / ready | kind, out_byte, out_last, peer_addr, host_available
//
// Packet bytes enter at one per cycle; the front end checks and queues one command per
// packet end or send request, and the back end drains the two-entry command queue.
// Results leave at one per cycle while out_if.ready holds: an echo reply streams from the
// packet store once its command leaves the queue; a send request gives 12 beats.
// The packet store holds two banks: input stalls while the bank being filled still
// waits to be echoed, and while the command queue is full.
// Synchronous active-low reset clears control state; no clearing pass is needed.
module icmp_echo_responder #(
  parameter int MAX_LEN = 64
) (
  input logic          clk,
  input logic          rst_n,
  icmp_er_in_if.sink   in_if,
  icmp_er_out_if.source out_if
);

  `include "icmp_echo_responder_macros.svh"

  localparam int AW        = $clog2(MAX_LEN);
  localparam int RAM_DEPTH = 2 * (1 << AW);

  logic              q_push;
  logic              q_wready;
  logic              q_pop;
  logic              q_rvalid;
  icmp_er_pkg::cmd_t q_wcmd;
  icmp_er_pkg::cmd_t q_rcmd;
  icmp_er_pkg::rel_t rel;
  logic              ram_we;
  logic [AW:0]       ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [AW:0]       ram_raddr;
  logic [7:0]        ram_rdata;
  logic              reply_beat;

  icmp_er_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .q_push    (q_push),
    .q_cmd     (q_wcmd),
    .q_wready  (q_wready),
    .rel       (rel),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  icmp_er_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wcmd),
    .wready (q_wready),
    .pop    (q_pop),
    .rvalid (q_rvalid),
    .rdata  (q_rcmd)
  );

  icmp_er_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  icmp_er_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_rvalid),
    .q_cmd     (q_rcmd),
    .q_pop     (q_pop),
    .rel       (rel),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_if    (out_if)
  );

  assign reply_beat = out_if.valid && (out_if.kind == icmp_er_pkg::KIND_REPLY);

  `ER_ASSERT(a_push_room, q_push |-> q_wready, "command pushed into a full queue")
  `ER_ASSERT(a_pop_data, q_pop |-> q_rvalid, "command popped from an empty queue")
  `ER_ASSERT(a_reply_flag, reply_beat |-> out_if.host_available, "reply beat without host flag")
  `ER_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_if.valid, "result valid just after reset")

endmodule

// ----- sv/icmp_er_ram.sv -----
module icmp_er_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/icmp_er_queue.sv -----
module icmp_er_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  icmp_er_pkg::cmd_t  wdata,
  output logic               wready,
  input  logic               pop,
  output logic               rvalid,
  output icmp_er_pkg::cmd_t  rdata
);

  icmp_er_pkg::cmd_t mem_r [2];
  logic              wp_r, wp_nxt;
  logic              rp_r, rp_nxt;
  logic [1:0]        cnt_r, cnt_nxt;

  assign wready = (cnt_r != 2'd2);
  assign rvalid = (cnt_r != 2'd0);
  assign rdata  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

// ----- sv/icmp_er_front.sv -----
module icmp_er_front #(
  parameter int MAX_LEN = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  icmp_er_in_if.sink                 in_if,
  output logic                       q_push,
  output icmp_er_pkg::cmd_t          q_cmd,
  input  logic                       q_wready,
  input  icmp_er_pkg::rel_t          rel,
  output logic                       ram_we,
  output logic [$clog2(MAX_LEN):0]   ram_waddr,
  output logic [7:0]                 ram_wdata
);

  localparam int AW = $clog2(MAX_LEN);

  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [15:0] rsum_r, rsum_nxt;
  logic [15:0] rcs_r, rcs_nxt;
  logic [7:0]  type_r;
  logic        wbank_r, wbank_nxt;
  logic [1:0]  busy_r, busy_nxt;

  logic        accept;
  logic        byte_acc;
  logic [7:0]  b;
  logic [15:0] word;
  logic        is_cs_hi;
  logic        is_cs_lo;
  logic [15:0] cnt_new;
  logic [15:0] sum_new;
  logic [15:0] rsum_new;
  logic [15:0] rcs_new;
  logic        ok;
  icmp_er_pkg::op_t op;

  assign b        = in_if.data_byte;
  assign in_if.ready = q_wready && !busy_r[wbank_r];
  assign accept   = in_if.valid && in_if.ready;
  assign byte_acc = accept && !in_if.req_type;

  always_comb begin
    word     = cnt_r[0] ? {8'h00, b} : {b, 8'h00};
    is_cs_hi = (cnt_r == 16'd2);
    is_cs_lo = (cnt_r == 16'd3);
    cnt_new  = (&cnt_r) ? cnt_r : cnt_r + 16'd1;
    sum_new  = (is_cs_hi || is_cs_lo) ? sum_r : icmp_er_pkg::oc_add(sum_r, word);
    rsum_new = (is_cs_hi || is_cs_lo || cnt_r == 16'd0) ? rsum_r
                                                        : icmp_er_pkg::oc_add(rsum_r, word);
    rcs_new  = is_cs_hi ? {b, rcs_r[7:0]} : (is_cs_lo ? {rcs_r[15:8], b} : rcs_r);
    ok       = (cnt_new >= icmp_er_pkg::HDR_MIN) && (rcs_new == ~sum_new);

    if (in_if.req_type) begin
      op = icmp_er_pkg::OP_PING;
    end else if (ok && type_r == icmp_er_pkg::TYPE_ECHO_REPLY) begin
      op = icmp_er_pkg::OP_REPLY;
    end else if (ok && type_r == icmp_er_pkg::TYPE_ECHO_REQ && cnt_new <= 16'(MAX_LEN)) begin
      op = icmp_er_pkg::OP_ECHO;
    end else begin
      op = icmp_er_pkg::OP_IGNORE;
    end

    q_push      = accept && (in_if.req_type || in_if.last_byte);
    q_cmd.op    = op;
    q_cmd.len   = cnt_new[icmp_er_pkg::LEN_W-1:0];
    q_cmd.bank  = wbank_r;
    q_cmd.cs    = ~rsum_new;
    q_cmd.addr  = in_if.ip_addr;

    ram_we    = byte_acc && (cnt_r < 16'(MAX_LEN));
    ram_waddr = {wbank_r, cnt_r[AW-1:0]};
    ram_wdata = b;

    cnt_nxt  = cnt_r;
    sum_nxt  = sum_r;
    rsum_nxt = rsum_r;
    rcs_nxt  = rcs_r;
    if (byte_acc) begin
      if (in_if.last_byte) begin
        cnt_nxt  = 16'd0;
        sum_nxt  = 16'd0;
        rsum_nxt = 16'd0;
        rcs_nxt  = 16'd0;
      end else begin
        cnt_nxt  = cnt_new;
        sum_nxt  = sum_new;
        rsum_nxt = rsum_new;
        rcs_nxt  = rcs_new;
      end
    end

    // Free a bank the back end releases; hand an echoed bank to the back end and move on to the other one.
    busy_nxt  = busy_r;
    wbank_nxt = wbank_r;
    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (q_push && op == icmp_er_pkg::OP_ECHO) begin
      busy_nxt[wbank_r] = 1'b1;
      wbank_nxt         = ~wbank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= 16'd0;
      sum_r   <= 16'd0;
      rsum_r  <= 16'd0;
      rcs_r   <= 16'd0;
      wbank_r <= 1'b0;
      busy_r  <= 2'b00;
    end else begin
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      rsum_r  <= rsum_nxt;
      rcs_r   <= rcs_nxt;
      wbank_r <= wbank_nxt;
      busy_r  <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_acc && cnt_r == 16'd0) begin
      type_r <= b;
    end
  end

endmodule

// ----- sv/icmp_er_back.sv -----
module icmp_er_back #(
  parameter int MAX_LEN = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  icmp_er_pkg::cmd_t          q_cmd,
  output logic                       q_pop,
  output icmp_er_pkg::rel_t          rel,
  output logic                       ram_re,
  output logic [$clog2(MAX_LEN):0]   ram_raddr,
  input  logic [7:0]                 ram_rdata,
  icmp_er_out_if.source              out_if
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = icmp_er_pkg::LEN_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_ECHO = 3'b010,
    S_PING = 3'b100
  } state_t;

  state_t         state_r, state_nxt;
  logic           flag_r, flag_nxt;
  logic [LW-1:0]  len_r, len_nxt;
  logic           bank_r, bank_nxt;
  logic [15:0]    cs_r, cs_nxt;
  logic [31:0]    addr_r, addr_nxt;
  logic [LW-1:0]  iss_r, iss_nxt;
  logic [LW-1:0]  pidx_r, pidx_nxt;
  logic           pend_r, pend_nxt;
  logic [3:0]     pcnt_r, pcnt_nxt;

  logic           ov_r, ov_nxt;
  logic [1:0]     okind_r;
  logic [7:0]     obyte_r;
  logic           olast_r;
  logic [31:0]    oaddr_r;
  logic           ohost_r;

  logic           can_load;
  logic           load;
  logic [1:0]     ld_kind;
  logic [7:0]     ld_byte;
  logic           ld_last;
  logic [31:0]    ld_addr;
  logic           ld_host;
  logic           issue;
  logic           echo_last;

  assign can_load  = !ov_r || out_if.ready;
  assign ram_raddr = {bank_r, iss_r[AW-1:0]};
  assign echo_last = (pidx_r == len_r - LW'(1));

  always_comb begin
    state_nxt = state_r;
    flag_nxt  = flag_r;
    len_nxt   = len_r;
    bank_nxt  = bank_r;
    cs_nxt    = cs_r;
    addr_nxt  = addr_r;
    iss_nxt   = iss_r;
    pidx_nxt  = pidx_r;
    pend_nxt  = pend_r;
    pcnt_nxt  = pcnt_r;
    q_pop     = 1'b0;
    issue     = 1'b0;
    load      = 1'b0;
    ld_kind   = icmp_er_pkg::KIND_BYTE;
    ld_byte   = 8'h00;
    ld_last   = 1'b0;
    ld_addr   = addr_r;
    ld_host   = flag_r;
    rel.valid = 1'b0;
    rel.bank  = bank_r;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            icmp_er_pkg::OP_REPLY: begin
              if (can_load) begin
                q_pop    = 1'b1;
                load     = 1'b1;
                ld_kind  = icmp_er_pkg::KIND_REPLY;
                ld_last  = 1'b1;
                ld_addr  = q_cmd.addr;
                ld_host  = 1'b1;
                flag_nxt = 1'b1;
              end
            end
            icmp_er_pkg::OP_IGNORE: begin
              if (can_load) begin
                q_pop   = 1'b1;
                load    = 1'b1;
                ld_kind = icmp_er_pkg::KIND_IGNORE;
                ld_last = 1'b1;
                ld_addr = q_cmd.addr;
              end
            end
            icmp_er_pkg::OP_ECHO: begin
              q_pop     = 1'b1;
              len_nxt   = q_cmd.len;
              bank_nxt  = q_cmd.bank;
              cs_nxt    = q_cmd.cs;
              addr_nxt  = q_cmd.addr;
              iss_nxt   = '0;
              pend_nxt  = 1'b0;
              state_nxt = S_ECHO;
            end
            icmp_er_pkg::OP_PING: begin
              q_pop     = 1'b1;
              flag_nxt  = 1'b0;
              addr_nxt  = q_cmd.addr;
              pcnt_nxt  = 4'd0;
              state_nxt = S_PING;
            end
            default: begin
              q_pop = 1'b0;
            end
          endcase
        end
      end
      S_PING: begin
        if (can_load) begin
          load     = 1'b1;
          ld_byte  = icmp_er_pkg::ping_byte(pcnt_r);
          ld_last  = (pcnt_r == icmp_er_pkg::PING_LAST);
          ld_host  = 1'b0;
          pcnt_nxt = pcnt_r + 4'd1;
          if (pcnt_r == icmp_er_pkg::PING_LAST) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_ECHO: begin
        // Fetch the next byte, until all len bytes are fetched, while none is held or the held one leaves this cycle.
        issue = (iss_r < len_r) && (!pend_r || can_load);
        load  = pend_r && can_load;
        if (pidx_r == LW'(0)) begin
          ld_byte = 8'h00;
        end else if (pidx_r == LW'(2)) begin
          ld_byte = cs_r[15:8];
        end else if (pidx_r == LW'(3)) begin
          ld_byte = cs_r[7:0];
        end else begin
          ld_byte = ram_rdata;
        end
        ld_last = echo_last;
        if (issue) begin
          iss_nxt  = iss_r + LW'(1);
          pidx_nxt = iss_r;
          pend_nxt = 1'b1;
        end else if (load) begin
          pend_nxt = 1'b0;
        end
        if (load && echo_last) begin
          rel.valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (load) begin
      ov_nxt = 1'b1;
    end else if (out_if.ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  assign ram_re = issue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      flag_r  <= 1'b0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      flag_r  <= flag_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    bank_r <= bank_nxt;
    cs_r   <= cs_nxt;
    addr_r <= addr_nxt;
    iss_r  <= iss_nxt;
    pidx_r <= pidx_nxt;
    pcnt_r <= pcnt_nxt;
    if (load) begin
      okind_r <= ld_kind;
      obyte_r <= ld_byte;
      olast_r <= ld_last;
      oaddr_r <= ld_addr;
      ohost_r <= ld_host;
    end
  end

  assign out_if.valid          = ov_r;
  assign out_if.kind           = okind_r;
  assign out_if.out_byte       = obyte_r;
  assign out_if.out_last       = olast_r;
  assign out_if.peer_addr      = oaddr_r;
  assign out_if.host_available = ohost_r;

endmodule
